[design/gsa_pkg.sv]
// Package for the global sequence alignment core.
// Types, constants and command/status structs; no dependencies.
`timescale 1ns / 1ps
package gsa_pkg;
    localparam int MaxLen = 32;
    localparam int Dim = MaxLen + 1;
    localparam int CellW = 16;
    localparam int LenW = $clog2(MaxLen + 1);
    localparam int IdxW = $clog2(Dim);
    localparam int AddrW = $clog2(Dim * Dim);
    localparam int PathW = $clog2(2 * MaxLen);
    localparam int StepW = $clog2(2 * MaxLen + 1);
    localparam logic [7:0] GapChar = 8'd45;

    localparam logic [1:0] OpAppendA = 2'd0;
    localparam logic [1:0] OpAppendB = 2'd1;
    localparam logic [1:0] OpRun = 2'd2;
    localparam logic [1:0] OpUnused = 2'd3;

    localparam logic [1:0] RegMatch = 2'd0;
    localparam logic [1:0] RegMismatch = 2'd1;
    localparam logic [1:0] RegGap = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] total_score;
        logic column_valid;
        logic [7:0] aligned_a;
        logic [7:0] aligned_b;
        logic overflowed;
        logic last_column;
    } t_out_beat;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic [7:0] symbol;
        logic init;
        logic fill_border;
        logic fill_inner;
        logic tb_start;
        logic tb_step;
        logic emit;
        logic emit_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic border_done;
        logic fill_done;
        logic tb_done;
        logic emit_done;
        logic empty;
    } t_status;
endpackage

[design/gsa_datapath.sv]
// Datapath: sequence stores, score matrix memory, fill and traceback.
// Depends on gsa_pkg; driven by gsa_ctrl commands.
`timescale 1ns / 1ps
module gsa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  gsa_pkg::t_cmd      i_cmd,
    output gsa_pkg::t_status   o_status,
    output logic               o_valid,
    output gsa_pkg::t_out_beat o_beat
);
    import gsa_pkg::*;

    logic signed [7:0] r_match, r_mism, r_gap;
    logic [7:0] r_seq_a [MaxLen];
    logic [7:0] r_seq_b [MaxLen];
    logic [LenW-1:0] r_len_a, r_len_b;
    logic r_ovf;
    logic signed [CellW-1:0] r_mem [Dim*Dim];
    logic [7:0] r_pa [2*MaxLen];
    logic [7:0] r_pb [2*MaxLen];

    // fill uses four-phase cells: three reads, then the write
    logic [IdxW-1:0] r_i, r_j;
    logic [1:0] r_ph;
    logic signed [CellW-1:0] r_rd, r_diag, r_up, r_here;
    logic signed [CellW-1:0] r_brd;
    logic [StepW-1:0] r_steps, r_k;
    logic signed [CellW-1:0] r_total;
    logic r_valid;
    t_out_beat r_beat;

    logic [AddrW-1:0] w_addr_rd;
    logic signed [CellW-1:0] w_pair, w_gap16, w_best, w_d, w_u, w_l;
    logic [IdxW-1:0] w_im1, w_jm1;

    assign w_im1 = r_i - 1'b1;
    assign w_jm1 = r_j - 1'b1;
    assign w_gap16 = CellW'(r_gap);
    assign w_pair = (r_seq_a[w_im1[LenW-2:0]] == r_seq_b[w_jm1[LenW-2:0]])
                    ? CellW'(r_match) : CellW'(r_mism);
    assign w_d = r_diag + w_pair;
    assign w_u = r_up + w_gap16;
    // left cell arrives on the read port in the write phase
    assign w_l = r_rd + w_gap16;
    always_comb begin
        w_best = w_d;
        if (w_u > w_best) w_best = w_u;
        if (w_l > w_best) w_best = w_l;
    end

    always_comb begin
        case (r_ph)
            2'd0: w_addr_rd = AddrW'(w_im1 * Dim + w_jm1);
            2'd1: w_addr_rd = AddrW'(w_im1 * Dim + r_j);
            2'd2: w_addr_rd = AddrW'(r_i * Dim + w_jm1);
            default: w_addr_rd = AddrW'(r_i * Dim + r_j);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_addr_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 8'sd1;
            r_mism <= -8'sd1;
            r_gap <= -8'sd2;
            r_len_a <= '0;
            r_len_b <= '0;
            r_ovf <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit | i_cmd.emit_empty;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    RegMatch: r_match <= i_cfg_data;
                    RegMismatch: r_mism <= i_cfg_data;
                    RegGap: r_gap <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_a) begin
                if (r_len_a < LenW'(MaxLen)) begin
                    r_seq_a[r_len_a[LenW-2:0]] <= i_cmd.symbol;
                    r_len_a <= r_len_a + 1'b1;
                end else r_ovf <= 1'b1;
            end
            if (i_cmd.load_b) begin
                if (r_len_b < LenW'(MaxLen)) begin
                    r_seq_b[r_len_b[LenW-2:0]] <= i_cmd.symbol;
                    r_len_b <= r_len_b + 1'b1;
                end else r_ovf <= 1'b1;
            end
            if (i_cmd.emit_empty) begin
                r_beat <= '{total_score: '0, column_valid: 1'b0, aligned_a: 8'd0,
                            aligned_b: 8'd0, overflowed: r_ovf, last_column: 1'b1};
            end
            if (i_cmd.emit) begin
                r_beat <= '{total_score: r_total, column_valid: 1'b1,
                            aligned_a: r_pa[r_k[PathW-1:0] - 1'b1],
                            aligned_b: r_pb[r_k[PathW-1:0] - 1'b1],
                            overflowed: r_ovf, last_column: r_k == StepW'(1)};
            end
            if (i_cmd.clear) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // fill and traceback sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_i <= '0;
            r_j <= '0;
            r_brd <= '0;
            r_ph <= 2'd0;
        end
        if (i_cmd.fill_border) begin
            // walk row 0 then column 0
            if (r_i == '0) begin
                r_mem[AddrW'(r_j)] <= r_brd;
                if (r_j == IdxW'(r_len_b)) begin
                    r_i <= IdxW'(1);
                    r_brd <= w_gap16;
                end else begin
                    r_j <= r_j + 1'b1;
                    r_brd <= r_brd + w_gap16;
                end
            end else begin
                if (r_i <= IdxW'(r_len_a)) r_mem[AddrW'(r_i * Dim)] <= r_brd;
                r_brd <= r_brd + w_gap16;
                if (r_i >= IdxW'(r_len_a)) begin
                    r_i <= IdxW'(1);
                    r_j <= IdxW'(1);
                end else r_i <= r_i + 1'b1;
            end
        end
        if (i_cmd.fill_inner) begin
            r_ph <= r_ph + 1'b1;
            case (r_ph)
                2'd1: r_diag <= r_rd;
                2'd2: r_up <= r_rd;
                2'd3: begin
                    r_mem[AddrW'(r_i * Dim + r_j)] <= w_best;
                    if (r_j == IdxW'(r_len_b)) begin
                        r_j <= IdxW'(1);
                        r_i <= r_i + 1'b1;
                    end else r_j <= r_j + 1'b1;
                end
                default: ;
            endcase
        end
        if (i_cmd.tb_start) begin
            r_i <= IdxW'(r_len_a);
            r_j <= IdxW'(r_len_b);
            r_ph <= 2'd3;
            r_steps <= '0;
        end
        if (i_cmd.tb_step) begin
            // phases: 3 read here, 0 read diag, 1 read up, 2 decide
            r_ph <= r_ph + 1'b1;
            case (r_ph)
                2'd0: begin
                    r_here <= r_rd;
                    if (r_steps == '0) r_total <= r_rd;
                end
                2'd1: r_diag <= r_rd;
                2'd2: begin
                    r_up <= r_rd;
                end
                default: ;
            endcase
        end
        if (i_cmd.tb_step && r_ph == 2'd2) begin
            if (r_i != '0 && r_j != '0 && r_here == r_diag + w_pair) begin
                r_pa[r_steps[PathW-1:0]] <= r_seq_a[w_im1[LenW-2:0]];
                r_pb[r_steps[PathW-1:0]] <= r_seq_b[w_jm1[LenW-2:0]];
                r_i <= w_im1;
                r_j <= w_jm1;
            end else if (r_i != '0 && (r_j == '0 || r_here == r_rd + w_gap16)) begin
                r_pa[r_steps[PathW-1:0]] <= r_seq_a[w_im1[LenW-2:0]];
                r_pb[r_steps[PathW-1:0]] <= GapChar;
                r_i <= w_im1;
            end else begin
                r_pa[r_steps[PathW-1:0]] <= GapChar;
                r_pb[r_steps[PathW-1:0]] <= r_seq_b[w_jm1[LenW-2:0]];
                r_j <= w_jm1;
            end
            r_steps <= r_steps + 1'b1;
            r_k <= r_steps + 1'b1;
        end
        if (i_cmd.emit) r_k <= r_k - 1'b1;
    end

    // total score is the bottom-right cell, captured at first traceback read
    always_comb begin
        o_status.border_done = r_i != '0 && r_i >= IdxW'(r_len_a);
        o_status.fill_done = (r_len_a == '0) || (r_len_b == '0) ||
                             (r_i > IdxW'(r_len_a));
        o_status.tb_done = (r_i == '0 && r_j == '0) || r_steps == StepW'(2 * MaxLen);
        o_status.emit_done = r_k == StepW'(1);
        o_status.empty = (r_len_a == '0) && (r_len_b == '0);
    end

    assign o_valid = r_valid;
    assign o_beat = r_beat;
endmodule

[design/gsa_ctrl.sv]
// Controller state machine for the alignment core.
// Depends on gsa_pkg; issues commands to gsa_datapath.
`timescale 1ns / 1ps
module gsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  gsa_pkg::t_in_beat i_beat,
    input  gsa_pkg::t_status i_status,
    output gsa_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import gsa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_BORDER = 7'b0000010,
        S_FILL   = 7'b0000100,
        S_TBINIT = 7'b0001000,
        S_TB     = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_ph;
    logic w_go;

    assign w_go = i_start && r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TB) r_ph <= r_ph + 1'b1;
            else r_ph <= 2'd3;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.symbol = i_beat.symbol;
        unique case (r_state)
            S_IDLE: if (w_go) begin
                o_cmd.load_a = i_beat.opcode == OpAppendA;
                o_cmd.load_b = i_beat.opcode == OpAppendB;
                if (i_beat.opcode == OpRun) begin
                    if (i_status.empty) begin
                        o_cmd.emit_empty = 1'b1;
                        o_cmd.clear = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_state = S_BORDER;
                    end
                end
            end
            S_BORDER: begin
                o_cmd.fill_border = 1'b1;
                if (i_status.border_done) n_state = S_FILL;
            end
            S_FILL: begin
                if (i_status.fill_done) n_state = S_TBINIT;
                else o_cmd.fill_inner = 1'b1;
            end
            S_TBINIT: begin
                o_cmd.tb_start = 1'b1;
                n_state = S_TB;
            end
            S_TB: begin
                if (r_ph == 2'd3 && i_status.tb_done) n_state = S_EMIT;
                else o_cmd.tb_step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_done) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
endmodule

[design/global_sequence_alignment_core.sv]
// Top level of the global sequence alignment core.
// Depends on gsa_pkg, gsa_ctrl and gsa_datapath.
//
// Usage: an item is taken when start is high and busy is low.
// Opcode append A/B stores one byte in a cycle; a full sequence drops
// the byte and sets the overflow flag. Opcode run fills the score matrix
// through one single-port memory, three reads and a write per inner cell,
// after a border pass over row 0 and then column 0; each traceback step
// reads the cell, its diagonal and upper neighbours, then decides, and the
// aligned columns come out one per cycle on o_valid/o_beat in forward order,
// last_column on the final beat. Two empty sequences give one beat with no column.
// Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Reset clears lengths, overflow and registers to their defaults.
// Results are shown for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
module global_sequence_alignment_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gsa_pkg::t_in_beat  i_beat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    output logic               o_valid,
    output gsa_pkg::t_out_beat o_beat
);
    import gsa_pkg::*;

    t_cmd w_cmd;
    t_status w_status;

    gsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_beat(i_beat),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(busy)
    );

    gsa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_cmd(w_cmd),
        .o_status(w_status), .o_valid(o_valid), .o_beat(o_beat)
    );
endmodule

[verif/global_sequence_alignment_core_test.sv]
// Testbench for global_sequence_alignment_core: directed and random load/run beats,
// with a scoreboard that checks each aligned column. Depends on gsa_pkg and the core RTL.
`timescale 1ns / 1ps
module global_sequence_alignment_core_test;
    import gsa_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in_beat           i_beat;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [7:0]         i_cfg_data;
    logic               o_valid;
    t_out_beat          o_beat;

    global_sequence_alignment_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_beat(i_beat),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_beat(o_beat)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    logic signed [7:0] match_val, mismatch_val, gap_val;
    logic [7:0]        seq_a [MaxLen];
    logic [7:0]        seq_b [MaxLen];
    int                len_a, len_b;
    logic              ovf;
    t_out_beat         column_q [$];
    int                n_items;
    int                n_fail;

    function automatic int pair_val(int i, int j);
        return (seq_a[i-1] == seq_b[j-1]) ? int'(match_val) : int'(mismatch_val);
    endfunction

    task automatic predict_alignment(input t_in_beat b);
        int        grid [0:MaxLen][0:MaxLen];
        logic [7:0] col_a [2*MaxLen];
        logic [7:0] col_b [2*MaxLen];
        int        i, j, steps, best, here, total;
        t_out_beat r;
        if (b.opcode == OpAppendA) begin
            if (len_a < MaxLen) begin
                seq_a[len_a] = b.symbol;
                len_a++;
            end else ovf = 1'b1;
        end else if (b.opcode == OpAppendB) begin
            if (len_b < MaxLen) begin
                seq_b[len_b] = b.symbol;
                len_b++;
            end else ovf = 1'b1;
        end else if (b.opcode == OpRun) begin
            for (i = 0; i <= len_a; i++) grid[i][0] = i * int'(gap_val);
            for (j = 0; j <= len_b; j++) grid[0][j] = j * int'(gap_val);
            for (i = 1; i <= len_a; i++) begin
                for (j = 1; j <= len_b; j++) begin
                    best = grid[i-1][j-1] + pair_val(i, j);
                    if (grid[i-1][j] + gap_val > best) best = grid[i-1][j] + gap_val;
                    if (grid[i][j-1] + gap_val > best) best = grid[i][j-1] + gap_val;
                    grid[i][j] = best;
                end
            end
            total = grid[len_a][len_b];
            r = '0;
            r.total_score = total[15:0];
            r.overflowed = ovf;
            if (len_a == 0 && len_b == 0) begin
                r.last_column = 1'b1;
                column_q.push_back(r);
            end else begin
                i = len_a;
                j = len_b;
                steps = 0;
                while ((i > 0 || j > 0) && steps < 2 * MaxLen) begin
                    here = grid[i][j];
                    if (i > 0 && j > 0 && here == grid[i-1][j-1] + pair_val(i, j)) begin
                        col_a[steps] = seq_a[i-1];
                        col_b[steps] = seq_b[j-1];
                        i--;
                        j--;
                    end else if (i > 0 && (j == 0 || here == grid[i-1][j] + gap_val)) begin
                        col_a[steps] = seq_a[i-1];
                        col_b[steps] = GapChar;
                        i--;
                    end else begin
                        col_a[steps] = GapChar;
                        col_b[steps] = seq_b[j-1];
                        j--;
                    end
                    steps++;
                end
                for (int k = steps - 1; k >= 0; k--) begin
                    r.column_valid = 1'b1;
                    r.aligned_a = col_a[k];
                    r.aligned_b = col_b[k];
                    r.last_column = (k == 0);
                    column_q.push_back(r);
                end
            end
            len_a = 0;
            len_b = 0;
            ovf = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [7:0] sym);
        t_in_beat b;
        int       gap;
        b.opcode = op;
        b.symbol = sym;
        start <= 1'b1;
        i_beat <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_alignment(b);
        n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (column_q.size() != 0 || busy) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_scores(input logic [7:0] m, input logic [7:0] mm, input logic [7:0] g);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx = '{RegMatch, RegMismatch, RegGap};
        val = '{m, mm, g};
        settle();
        for (int k = 0; k < 3; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        match_val = m;
        mismatch_val = mm;
        gap_val = g;
    endtask

    task automatic load_pair(input string a, input string b);
        for (int k = 0; k < a.len(); k++) send_beat(OpAppendA, a[k]);
        for (int k = 0; k < b.len(); k++) send_beat(OpAppendB, b[k]);
    endtask

    task automatic test_empty_run();
        send_beat(OpRun, 8'h00);
    endtask

    task automatic test_defaults();
        load_pair("GATT", "GCAT");
        send_beat(OpRun, 8'hff);
        send_beat(OpUnused, 8'h5a);
        load_pair("AC", "");
        send_beat(OpRun, 8'h00);
        load_pair("", "T");
        send_beat(OpRun, 8'h00);
    endtask

    task automatic test_overflow();
        for (int k = 0; k < MaxLen + 2; k++) send_beat(OpAppendA, (k % 2) ? 8'h00 : 8'hff);
        send_beat(OpAppendB, 8'hff);
        send_beat(OpRun, 8'h00);
    endtask

    task automatic test_score_extremes();
        write_scores(8'h7f, 8'h80, 8'h80);
        load_pair("ABBA", "ABA");
        send_beat(OpRun, 8'h00);
        write_scores(8'h80, 8'h7f, 8'h7f);
        load_pair("XY", "YXZ");
        send_beat(OpRun, 8'h00);
        write_scores(8'h00, 8'h00, 8'h00);
        load_pair("QQ", "Q");
        send_beat(OpRun, 8'h00);
    endtask

    task automatic test_random_runs();
        int         la, lb, na, nb, runs;
        logic [7:0] alpha [4];
        bit         narrow;
        runs = 0;
        while (n_items < 270) begin
            if (runs % 8 == 7)
                write_scores(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) begin
                la = $urandom_range(0, MaxLen + 2);
                lb = $urandom_range(0, MaxLen + 2);
            end else begin
                la = $urandom_range(0, 6);
                lb = $urandom_range(0, 6);
            end
            narrow = ($urandom_range(0, 4) != 0);
            foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
            na = 0;
            nb = 0;
            while (na < la || nb < lb) begin
                if ($urandom_range(0, 19) == 0) send_beat(OpUnused, 8'($urandom_range(0, 255)));
                if (nb >= lb || (na < la && $urandom_range(0, 1))) begin
                    send_beat(OpAppendA, narrow ? alpha[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255)));
                    na++;
                end else begin
                    send_beat(OpAppendB, narrow ? alpha[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255)));
                    nb++;
                end
            end
            send_beat(OpRun, 8'($urandom_range(0, 255)));
            runs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid) begin
            if (column_q.size() == 0) begin
                $error("unexpected result beat");
                n_fail++;
            end else begin
                want = column_q.pop_front();
                if (o_beat.total_score !== want.total_score) begin
                    $error("total_score exp %0d got %0d", want.total_score, o_beat.total_score);
                    n_fail++;
                end
                if (o_beat.column_valid !== want.column_valid) begin
                    $error("column_valid exp %0d got %0d", want.column_valid,
                           o_beat.column_valid);
                    n_fail++;
                end
                if (o_beat.aligned_a !== want.aligned_a) begin
                    $error("aligned_a exp %0d got %0d", want.aligned_a, o_beat.aligned_a);
                    n_fail++;
                end
                if (o_beat.aligned_b !== want.aligned_b) begin
                    $error("aligned_b exp %0d got %0d", want.aligned_b, o_beat.aligned_b);
                    n_fail++;
                end
                if (o_beat.overflowed !== want.overflowed) begin
                    $error("overflowed exp %0d got %0d", want.overflowed, o_beat.overflowed);
                    n_fail++;
                end
                if (o_beat.last_column !== want.last_column) begin
                    $error("last_column exp %0d got %0d", want.last_column,
                           o_beat.last_column);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        n_items = 0;
        n_fail = 0;
        match_val = 8'sd1;
        mismatch_val = -8'sd1;
        gap_val = -8'sd2;
        len_a = 0;
        len_b = 0;
        ovf = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_beat = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_run();
        test_defaults();
        test_overflow();
        test_score_extremes();
        test_random_runs();

        settle();
        if (n_fail == 0 && column_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[filelist.f]
design/gsa_pkg.sv
design/gsa_datapath.sv
design/gsa_ctrl.sv
design/global_sequence_alignment_core.sv
verif/global_sequence_alignment_core_test.sv
